[design/mld_pkg.sv]
package mld_pkg;

    localparam int unsigned PITCH_LIMIT  = 23014;
    localparam int unsigned FULL_TURN    = 92160;
    localparam int unsigned HALF_TURN    = 46080;
    localparam int unsigned QUARTER_TURN = 23040;

    // pi in Q30 split as HALF_TURN * PI_QUO + PI_REM
    localparam int unsigned PI_QUO = 73204;
    localparam int unsigned PI_REM = 19106;

    // multiple of a full turn that keeps the wrapped yaw sum positive
    localparam int unsigned YAW_BIAS = FULL_TURN * 8192;

    // floor(w / 45) is (w * RECIP_45) >> 25 for w below 780000
    localparam int unsigned RECIP_45 = 745655;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic [15:0] SENS_RESET = 16'd410;
    localparam logic [16:0] YAW_RESET  = 17'd69120;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW   = 2'd2;

    typedef logic [4:0] t_atan_idx;

    typedef struct packed {
        logic start;
    } t_cordic_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // truncated arctangent of 2^-i in Q30
    function automatic logic [29:0] atan_q30(input t_atan_idx idx);
        logic [29:0] v;
        v = '0;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/mld_cordic.sv]
module mld_cordic #(
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mld_pkg::t_cordic_ctrl i_ctrl,
    input  logic signed [32:0]   i_angle,
    output logic signed [31:0]   o_cos,
    output logic signed [31:0]   o_sin,
    output mld_pkg::t_cordic_stat o_stat
);

    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic signed [32:0]  r_z;

    logic signed [31:0]  sh_x;
    logic signed [31:0]  sh_y;
    logic signed [32:0]  at;

    assign sh_x = r_y >>> r_step;
    assign sh_y = r_x >>> r_step;
    assign at   = $signed({3'b000, mld_pkg::atan_q30(mld_pkg::t_atan_idx'(r_step))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_step <= '0;
            r_x    <= mld_pkg::GAIN_Q30;
            r_y    <= '0;
            r_z    <= i_angle;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (!r_z[32]) begin
                r_x <= r_x - sh_x;
                r_y <= r_y + sh_y;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + sh_x;
                r_y <= r_y - sh_y;
                r_z <= r_z + at;
            end
        end
    end

    assign o_cos       = r_x;
    assign o_sin       = r_y;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[design/mouse_look_direction_update.sv]
// channel   dir  handshake                    payload
// s_axis    in   i_s_axis_tvalid / o_..tready cursor_x [11:0], cursor_y [23:12]
// m_axis    out  o_m_axis_tvalid / i_..tready dir_x [15:0], dir_y [31:16], dir_z [47:32]
// cfg       in   i_cfg_valid / o_cfg_ready    index 0 sensitivity, 1 start_pitch, 2 start_yaw
//
// a transaction runs the shared cordic once for pitch and once for yaw before the next one;
// yaw wrap and degree-to-radian scaling are reciprocal multiplies on the shared multiplier
// input is not ready while a transaction is in flight; a finished result sits in the
// output register, so the next transaction can be taken while it waits
// synchronous active-low reset loads the reset angles and arms the first-sample flag
module mouse_look_direction_update #(
    parameter int COORD_BITS   = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // cursor_x, cursor_y
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // dir_x, dir_y, dir_z
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int CW = COORD_BITS;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_MUL_X    = 13'b0000000000010,
        ST_MUL_Y    = 13'b0000000000100,
        ST_PITCH    = 13'b0000000001000,
        ST_YAW_MOD  = 13'b0000000010000,
        ST_CONV_A   = 13'b0000000100000,
        ST_CONV_B   = 13'b0000001000000,
        ST_DIV_Q    = 13'b0000010000000,
        ST_ROT_GO   = 13'b0000100000000,
        ST_ROT_WAIT = 13'b0001000000000,
        ST_FIN_X    = 13'b0010000000000,
        ST_FIN_Z    = 13'b0100000000000,
        ST_FIN_D    = 13'b1000000000000
    } t_state;

    t_state              r_state;
    logic                r_o_valid;
    logic [47:0]         r_o_data;
    logic [15:0]         r_sens;
    logic signed [15:0]  r_pitch;
    logic [16:0]         r_yaw;
    logic [CW-1:0]       r_last_x;
    logic [CW-1:0]       r_last_y;
    logic                r_first;
    logic                r_second;

    logic signed [CW:0]  r_dx;
    logic signed [CW:0]  r_dy;
    logic signed [63:0]  r_prod;
    logic [31:0]         r_rem;
    logic [14:0]         r_mag;
    logic                r_neg;
    logic                r_flip;
    logic signed [31:0]  r_cp;
    logic signed [31:0]  r_sp;
    logic signed [31:0]  r_cy;
    logic signed [31:0]  r_sy;
    logic signed [15:0]  r_dirx;

    logic [15:0]         x_ext;
    logic [15:0]         y_ext;
    logic [CW-1:0]       cur_x;
    logic [CW-1:0]       cur_y;
    logic                in_acc;
    logic                out_acc;
    logic                cfg_acc;

    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic                mul_en;
    logic signed [63:0]  mul_p;

    logic signed [35:0]  scl_sum;
    logic signed [31:0]  scl;
    logic signed [32:0]  yaw_sum;
    logic signed [32:0]  pitch_sum;
    logic signed [15:0]  pitch_sat;

    logic [16:0]         yaw_mod;

    logic signed [17:0]  yaw_s;
    logic signed [17:0]  ang;
    logic signed [17:0]  fold_a;
    logic                fold_flip;
    logic signed [17:0]  fold_abs;
    logic [14:0]         mag_c;

    logic [31:0]         z_mag;
    logic signed [32:0]  z_q30;

    logic signed [31:0]  cos_f;
    logic signed [31:0]  sin_f;
    logic signed [15:0]  dirx_c;
    logic signed [15:0]  diry_c;
    logic signed [15:0]  dirz_c;
    logic signed [63:0]  sp_ext;

    logic signed [15:0]  cfg_pitch;
    logic [16:0]         cfg_yaw;

    mld_pkg::t_cordic_ctrl cord_ctrl;
    mld_pkg::t_cordic_stat cord_stat;
    logic signed [31:0]    cord_cos;
    logic signed [31:0]    cord_sin;

    function automatic logic signed [15:0] clamp_q14(input logic signed [63:0] t);
        if (t > 64'sd16384) begin
            return 16'sd16384;
        end else if (t < -64'sd16384) begin
            return -16'sd16384;
        end else begin
            return t[15:0];
        end
    endfunction

    assign x_ext   = {4'b0000, i_s_axis_tdata[11:0]};
    assign y_ext   = {4'b0000, i_s_axis_tdata[23:12]};
    assign cur_x   = x_ext[CW-1:0];
    assign cur_y   = y_ext[CW-1:0];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = r_o_valid && i_m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc = i_cfg_valid;

    // shared multiplier
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (r_state)
            ST_MUL_X: begin
                mul_a = 32'(r_dx);
                mul_b = $signed({16'd0, r_sens});
            end
            ST_MUL_Y: begin
                mul_a = 32'(r_dy);
                mul_b = $signed({16'd0, r_sens});
            end
            ST_PITCH: begin
                // full turn is 45 << 11
                mul_a = $signed({11'd0, r_rem[31:11]});
                mul_b = 32'(mld_pkg::RECIP_45);
            end
            ST_YAW_MOD: begin
                mul_a = $signed({17'd0, r_prod[39:25]});
                mul_b = 32'(mld_pkg::FULL_TURN);
            end
            ST_CONV_A: begin
                mul_a = $signed({17'd0, mag_c});
                mul_b = 32'(mld_pkg::PI_REM);
            end
            ST_CONV_B: begin
                mul_a = $signed({17'd0, r_mag});
                mul_b = 32'(mld_pkg::PI_QUO);
            end
            ST_DIV_Q: begin
                // half turn is 45 << 10
                mul_a = $signed({10'd0, r_rem[31:10]});
                mul_b = 32'(mld_pkg::RECIP_45);
            end
            ST_FIN_X: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
            ST_FIN_Z: begin
                mul_a = r_sy;
                mul_b = r_cp;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // scaled delta in 1/256 degree, rounded half up
    assign scl_sum   = $signed(r_prod[35:0]) + 36'sd8;
    assign scl       = scl_sum[35:4];
    assign yaw_sum   = $signed({16'd0, r_yaw}) + $signed({scl[31], scl})
                       + $signed({1'b0, 32'(mld_pkg::YAW_BIAS)});
    assign pitch_sum = $signed({{17{r_pitch[15]}}, r_pitch}) + $signed({scl[31], scl});

    always_comb begin
        if (pitch_sum > $signed(33'(mld_pkg::PITCH_LIMIT))) begin
            pitch_sat = 16'(mld_pkg::PITCH_LIMIT);
        end else if (pitch_sum < -$signed(33'(mld_pkg::PITCH_LIMIT))) begin
            pitch_sat = -16'(mld_pkg::PITCH_LIMIT);
        end else begin
            pitch_sat = pitch_sum[15:0];
        end
    end

    // biased yaw sum less whole turns
    assign yaw_mod = r_rem[16:0] - mul_p[16:0];

    // fold the angle into a quarter turn either side of zero
    assign yaw_s = (r_yaw >= 17'(mld_pkg::HALF_TURN))
                   ? $signed({1'b0, r_yaw}) - $signed(18'(mld_pkg::FULL_TURN))
                   : $signed({1'b0, r_yaw});
    assign ang   = r_second ? yaw_s : $signed({{2{r_pitch[15]}}, r_pitch});

    always_comb begin
        fold_a    = ang;
        fold_flip = 1'b0;
        if (ang > $signed(18'(mld_pkg::QUARTER_TURN))) begin
            fold_a    = ang - $signed(18'(mld_pkg::HALF_TURN));
            fold_flip = 1'b1;
        end else if (ang < -$signed(18'(mld_pkg::QUARTER_TURN))) begin
            fold_a    = ang + $signed(18'(mld_pkg::HALF_TURN));
            fold_flip = 1'b1;
        end
    end

    assign fold_abs = fold_a[17] ? -fold_a : fold_a;
    assign mag_c    = fold_abs[14:0];

    assign z_mag = r_rem + {17'd0, r_prod[39:25]};
    assign z_q30 = r_neg ? -$signed({1'b0, z_mag}) : $signed({1'b0, z_mag});

    assign cord_ctrl.start = (r_state == ST_ROT_GO);

    mld_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cord_ctrl),
        .i_angle (z_q30),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin),
        .o_stat  (cord_stat)
    );

    assign cos_f = r_flip ? -cord_cos : cord_cos;
    assign sin_f = r_flip ? -cord_sin : cord_sin;

    assign sp_ext = {{32{r_sp[31]}}, r_sp};
    assign dirx_c = clamp_q14((r_prod + (64'sd1 <<< 45)) >>> 46);
    assign dirz_c = clamp_q14((r_prod + (64'sd1 <<< 45)) >>> 46);
    assign diry_c = clamp_q14((sp_ext + 64'sd32768) >>> 16);

    // config values as loaded into the angles
    always_comb begin
        cfg_pitch = $signed(i_cfg_data[15:0]);
        if ($signed(i_cfg_data[15:0]) > $signed(16'(mld_pkg::PITCH_LIMIT))) begin
            cfg_pitch = 16'(mld_pkg::PITCH_LIMIT);
        end else if ($signed(i_cfg_data[15:0]) < -$signed(16'(mld_pkg::PITCH_LIMIT))) begin
            cfg_pitch = -16'(mld_pkg::PITCH_LIMIT);
        end
        cfg_yaw = i_cfg_data;
        if (i_cfg_data >= 17'(mld_pkg::FULL_TURN)) begin
            cfg_yaw = i_cfg_data - 17'(mld_pkg::FULL_TURN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_sens    <= mld_pkg::SENS_RESET;
            r_pitch   <= '0;
            r_yaw     <= mld_pkg::YAW_RESET;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_first   <= 1'b1;
            r_second  <= 1'b0;
        end else begin
            if (out_acc) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_last_x <= cur_x;
                        r_last_y <= cur_y;
                        r_first  <= 1'b0;
                        r_second <= 1'b0;
                        r_state  <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    r_state <= ST_MUL_Y;
                end
                ST_MUL_Y: begin
                    r_state <= ST_PITCH;
                end
                ST_PITCH: begin
                    r_pitch <= pitch_sat;
                    r_state <= ST_YAW_MOD;
                end
                ST_YAW_MOD: begin
                    r_yaw   <= yaw_mod;
                    r_state <= ST_CONV_A;
                end
                ST_CONV_A: begin
                    r_state <= ST_CONV_B;
                end
                ST_CONV_B: begin
                    r_state <= ST_DIV_Q;
                end
                ST_DIV_Q: begin
                    r_state <= ST_ROT_GO;
                end
                ST_ROT_GO: begin
                    r_state <= ST_ROT_WAIT;
                end
                ST_ROT_WAIT: begin
                    if (cord_stat.done) begin
                        if (!r_second) begin
                            r_second <= 1'b1;
                            r_state  <= ST_CONV_A;
                        end else begin
                            r_state  <= ST_FIN_X;
                        end
                    end
                end
                ST_FIN_X: begin
                    r_state <= ST_FIN_Z;
                end
                ST_FIN_Z: begin
                    r_state <= ST_FIN_D;
                end
                ST_FIN_D: begin
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    mld_pkg::CFG_SENS:  r_sens  <= i_cfg_data[15:0];
                    mld_pkg::CFG_PITCH: r_pitch <= cfg_pitch;
                    mld_pkg::CFG_YAW:   r_yaw   <= cfg_yaw;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (in_acc) begin
            if (r_first) begin
                r_dx <= '0;
                r_dy <= '0;
            end else begin
                r_dx <= $signed({1'b0, cur_x}) - $signed({1'b0, r_last_x});
                r_dy <= $signed({1'b0, r_last_y}) - $signed({1'b0, cur_y});
            end
        end
        if (r_state == ST_MUL_Y) begin
            r_rem <= yaw_sum[31:0];
        end
        if (r_state == ST_DIV_Q) begin
            r_rem <= r_prod[31:0];
        end
        if (r_state == ST_CONV_A) begin
            r_mag  <= mag_c;
            r_neg  <= fold_a[17];
            r_flip <= fold_flip;
        end
        if (r_state == ST_CONV_B) begin
            r_rem <= r_prod[31:0] + 32'(mld_pkg::QUARTER_TURN);
        end
        if (r_state == ST_ROT_WAIT && cord_stat.done) begin
            if (!r_second) begin
                r_cp <= cos_f;
                r_sp <= sin_f;
            end else begin
                r_cy <= cos_f;
                r_sy <= sin_f;
            end
        end
        if (r_state == ST_FIN_Z) begin
            r_dirx <= dirx_c;
        end
        if (r_state == ST_FIN_D && (!r_o_valid || i_m_axis_tready)) begin
            r_o_data <= {dirz_c, diry_c, r_dirx};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= $signed(16'(mld_pkg::PITCH_LIMIT)))
        && (r_pitch >= -$signed(16'(mld_pkg::PITCH_LIMIT))))
        else $error("pitch outside limit");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < 17'(mld_pkg::FULL_TURN))
        else $error("yaw not wrapped");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_stat.done |-> (r_state == ST_ROT_WAIT))
        else $error("cordic finished outside wait state");

    a_cordic_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_ctrl.start |-> !cord_stat.busy)
        else $error("cordic restarted while busy");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_MUL_X))
        else $error("accepted transaction not started");

endmodule
